// File: src/tccr_pkg.sv
// tccr_pkg: shared constants, codes and result type of the tile cache replacement block
// no dependencies; used by tccr_ctrl and tile_cache_frame_protected_replace_top

package tccr_pkg;

    localparam int SLOT_COUNT  = 256;
    localparam int ENTRY_SHIFT = 3;
    localparam int MAX_LOADS   = 64;
    localparam int TILE_BITS   = 19;

    localparam int ENTRY_BITS  = TILE_BITS - ENTRY_SHIFT;
    localparam int ENTRY_COUNT = 1 << ENTRY_BITS;
    localparam int OFFSET_MASK = (1 << ENTRY_SHIFT) - 1;
    localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
    localparam int USED_BITS   = $clog2(SLOT_COUNT + 1);
    localparam int LOAD_BITS   = $clog2(MAX_LOADS + 1);
    localparam int STAMP_BITS  = 16;

    localparam int MAP_W   = SLOT_BITS + 1;
    localparam int SLOTW_W = ENTRY_BITS + STAMP_BITS;

    localparam int SWEEP_LEN  = (ENTRY_COUNT > SLOT_COUNT) ? ENTRY_COUNT : SLOT_COUNT;
    localparam int SWEEP_BITS = $clog2(SWEEP_LEN);

    localparam int TILE_IN_W    = 19;
    localparam int IN_DATA_W    = ((TILE_IN_W + 7) / 8) * 8;
    localparam int SLOT_OUT_W   = 8;
    localparam int TEX_W        = 11;
    localparam int EVICT_W      = 16;
    localparam int POS_W        = 6;
    localparam int OUT_FIELDS_W = SLOT_OUT_W + TEX_W + EVICT_W + POS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_FRAME   = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_LOADED  = 2'd1,
        ST_FAILED  = 2'd2,
        ST_FRAME   = 2'd3
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_OUT_W-1:0]   slot;
        logic [TEX_W-1:0]        texture_tile;
        logic [EVICT_W-1:0]      evicted_entry;
        logic [POS_W-1:0]        load_position;
    } result_t;

endpackage

// File: src/tile_cache_frame_protected_replace_top.sv
// tile_cache_frame_protected_replace_top: tile cache slot mapping with frame-protected replacement
// depends on tccr_pkg, tccr_ram and tccr_ctrl

// usage
// - input words on s_axis: tuser is the operation (request tile / start frame),
//   tdata carries the tile number; one result word per input word on m_axis
// - a request looks the tile's entry up in the entry map; on a miss a round-robin
//   scan over the slot ram skips slots already stamped with the current frame,
//   unmaps the victim's old entry and installs the new one
// - one item in flight; a miss scans 1 to slot count slots, one slot checked
//   per cycle through the single port of the slot ram
// - a result sits in an output register, so the next word is taken while it
//   waits; a stalled m_axis holds the register and the sequencer waits with the
//   following result
// - after reset an init pass over max(entry count, slot count) = 65536 addresses
//   writes the entry map and the slot ram; s_axis_tready stays low meanwhile

module tile_cache_frame_protected_replace_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tccr_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // tile_number
    input  logic                                s_axis_tuser,   // operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tccr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // slot, texture_tile, evicted_entry, load_position
    output logic [1:0]                          m_axis_tuser    // status
);

    logic                                 res_valid;
    logic                                 res_ready;
    tccr_pkg::result_t                    res;
    logic [tccr_pkg::ENTRY_BITS-1:0]      map_addr;
    logic                                 map_we;
    logic [tccr_pkg::MAP_W-1:0]           map_wdata;
    logic [tccr_pkg::MAP_W-1:0]           map_rdata;
    logic [tccr_pkg::SLOT_BITS-1:0]       slot_addr;
    logic                                 slot_we;
    logic [tccr_pkg::SLOTW_W-1:0]         slot_wdata;
    logic [tccr_pkg::SLOTW_W-1:0]         slot_rdata;

    logic                                 out_valid_reg, out_valid_next;
    tccr_pkg::result_t                    out_data_reg, out_data_next;

    tccr_ram #(
        .WIDTH (tccr_pkg::MAP_W),
        .DEPTH (tccr_pkg::ENTRY_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .addr  (map_addr),
        .we    (map_we),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    tccr_ram #(
        .WIDTH (tccr_pkg::SLOTW_W),
        .DEPTH (tccr_pkg::SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .addr  (slot_addr),
        .we    (slot_we),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    tccr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_tile    (tccr_pkg::TILE_BITS'(s_axis_tdata[tccr_pkg::TILE_IN_W-1:0])),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .map_addr   (map_addr),
        .map_we     (map_we),
        .map_wdata  (map_wdata),
        .map_rdata  (map_rdata),
        .slot_addr  (slot_addr),
        .slot_we    (slot_we),
        .slot_wdata (slot_wdata),
        .slot_rdata (slot_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.status;
    assign m_axis_tdata  = {{tccr_pkg::OUT_PAD_W{1'b0}},
                            out_data_reg.load_position,
                            out_data_reg.evicted_entry,
                            out_data_reg.texture_tile,
                            out_data_reg.slot};

endmodule

// File: src/tccr_ram.sv
// tccr_ram: generic single-port synchronous ram, read-first, registered read data
// no dependencies

module tccr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] addr,
    input  logic              we,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/tccr_ctrl.sv
// tccr_ctrl: sequencer for lookup, victim scan, replacement and frame bookkeeping
// depends on tccr_pkg; drives the entry map ram and the slot ram

module tccr_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_op,
    input  logic [tccr_pkg::TILE_BITS-1:0]        in_tile,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output tccr_pkg::result_t                     res,
    output logic [tccr_pkg::ENTRY_BITS-1:0]       map_addr,
    output logic                                  map_we,
    output logic [tccr_pkg::MAP_W-1:0]            map_wdata,
    input  logic [tccr_pkg::MAP_W-1:0]            map_rdata,
    output logic [tccr_pkg::SLOT_BITS-1:0]        slot_addr,
    output logic                                  slot_we,
    output logic [tccr_pkg::SLOTW_W-1:0]          slot_wdata,
    input  logic [tccr_pkg::SLOTW_W-1:0]          slot_rdata
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_MAP,
        S_HIT,
        S_SCAN,
        S_VICTIM,
        S_INSTALL,
        S_RESULT
    } state_t;

    state_t                                state_reg, state_next;
    logic [tccr_pkg::SWEEP_BITS-1:0]       sweep_reg, sweep_next;
    logic [tccr_pkg::TILE_BITS-1:0]        tile_reg, tile_next;
    logic [tccr_pkg::SLOT_BITS-1:0]        slot_reg, slot_next;
    logic [tccr_pkg::SLOT_BITS-1:0]        ptr_reg, ptr_next;
    logic [tccr_pkg::SLOT_BITS-1:0]        scan_reg, scan_next;
    logic [tccr_pkg::USED_BITS-1:0]        steps_reg, steps_next;
    logic [tccr_pkg::ENTRY_BITS-1:0]       evict_reg, evict_next;
    logic [tccr_pkg::STAMP_BITS-1:0]       frame_reg, frame_next;
    logic [tccr_pkg::USED_BITS-1:0]        used_reg, used_next;
    logic [tccr_pkg::LOAD_BITS-1:0]        loads_reg, loads_next;
    tccr_pkg::result_t                     res_reg, res_next;

    logic                                  map_hit;
    logic [tccr_pkg::SLOT_BITS-1:0]        map_slot;
    logic [tccr_pkg::STAMP_BITS-1:0]       rd_stamp;
    logic [tccr_pkg::ENTRY_BITS-1:0]       rd_owner;
    logic [tccr_pkg::ENTRY_BITS-1:0]       entry_cur;
    logic [tccr_pkg::SLOT_BITS-1:0]        scan_first;
    logic [tccr_pkg::SLOT_BITS-1:0]        scan_after;
    logic                                  sweep_in_map;
    logic                                  sweep_in_slot;

    function automatic logic [tccr_pkg::SLOT_BITS-1:0] next_slot(
        input logic [tccr_pkg::SLOT_BITS-1:0] p
    );
        if (p == tccr_pkg::SLOT_BITS'(tccr_pkg::SLOT_COUNT - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic tccr_pkg::result_t make_result(
        input tccr_pkg::status_t               st,
        input logic [tccr_pkg::SLOT_BITS-1:0]  s,
        input logic [tccr_pkg::TILE_BITS-1:0]  t,
        input logic [tccr_pkg::ENTRY_BITS-1:0] ev,
        input logic [tccr_pkg::LOAD_BITS-1:0]  pos
    );
        tccr_pkg::result_t r;
        r.status        = st;
        r.slot          = tccr_pkg::SLOT_OUT_W'(s);
        r.texture_tile  = tccr_pkg::TEX_W'((32'(s) << tccr_pkg::ENTRY_SHIFT)
                          + (32'(t) & tccr_pkg::OFFSET_MASK));
        r.evicted_entry = tccr_pkg::EVICT_W'(ev);
        r.load_position = tccr_pkg::POS_W'(pos);
        return r;
    endfunction

    assign map_hit    = map_rdata[tccr_pkg::MAP_W-1];
    assign map_slot   = map_rdata[tccr_pkg::SLOT_BITS-1:0];
    assign rd_stamp   = slot_rdata[tccr_pkg::STAMP_BITS-1:0];
    assign rd_owner   = slot_rdata[tccr_pkg::SLOTW_W-1:tccr_pkg::STAMP_BITS];
    assign entry_cur  = tile_reg[tccr_pkg::TILE_BITS-1:tccr_pkg::ENTRY_SHIFT];
    assign scan_first = next_slot(ptr_reg);
    assign scan_after = next_slot(scan_reg);
    assign sweep_in_map  = (32'(sweep_reg) < tccr_pkg::ENTRY_COUNT);
    assign sweep_in_slot = (32'(sweep_reg) < tccr_pkg::SLOT_COUNT);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        tile_next  = tile_reg;
        slot_next  = slot_reg;
        ptr_next   = ptr_reg;
        scan_next  = scan_reg;
        steps_next = steps_reg;
        evict_next = evict_reg;
        frame_next = frame_reg;
        used_next  = used_reg;
        loads_next = loads_reg;
        res_next   = res_reg;
        map_addr   = entry_cur;
        map_we     = 1'b0;
        map_wdata  = '0;
        slot_addr  = slot_reg;
        slot_we    = 1'b0;
        slot_wdata = '0;

        unique case (state_reg)
            S_SWEEP:
            begin
                map_addr   = sweep_reg[tccr_pkg::ENTRY_BITS-1:0];
                map_we     = sweep_in_map;
                map_wdata  = {sweep_in_slot, sweep_reg[tccr_pkg::SLOT_BITS-1:0]};
                slot_addr  = sweep_reg[tccr_pkg::SLOT_BITS-1:0];
                slot_we    = sweep_in_slot;
                slot_wdata = {sweep_reg[tccr_pkg::ENTRY_BITS-1:0],
                              tccr_pkg::STAMP_BITS'(0)};
                if (sweep_reg == tccr_pkg::SWEEP_BITS'(tccr_pkg::SWEEP_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == tccr_pkg::OP_FRAME)
                    begin
                        frame_next = frame_reg + 1'b1;
                        used_next  = '0;
                        loads_next = '0;
                        res_next   = '0;
                        res_next.status = tccr_pkg::ST_FRAME;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        tile_next  = in_tile;
                        map_addr   = in_tile[tccr_pkg::TILE_BITS-1:tccr_pkg::ENTRY_SHIFT];
                        state_next = S_MAP;
                    end
                end
            end
            S_MAP:
            begin
                if (map_hit)
                begin
                    slot_next  = map_slot;
                    slot_addr  = map_slot;
                    state_next = S_HIT;
                end
                else if (used_reg >= tccr_pkg::USED_BITS'(tccr_pkg::SLOT_COUNT) ||
                         loads_reg >= tccr_pkg::LOAD_BITS'(tccr_pkg::MAX_LOADS))
                begin
                    res_next   = '0;
                    res_next.status = tccr_pkg::ST_FAILED;
                    state_next = S_RESULT;
                end
                else
                begin
                    slot_addr  = scan_first;
                    scan_next  = scan_first;
                    steps_next = tccr_pkg::USED_BITS'(1);
                    state_next = S_SCAN;
                end
            end
            S_HIT:
            begin
                if (rd_stamp != frame_reg)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {rd_owner, frame_reg};
                    used_next  = used_reg + 1'b1;
                end
                res_next   = make_result(tccr_pkg::ST_HIT, slot_reg, tile_reg, '0, '0);
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (rd_stamp != frame_reg)
                begin
                    slot_next  = scan_reg;
                    ptr_next   = scan_reg;
                    evict_next = rd_owner;
                    map_addr   = rd_owner;
                    state_next = S_VICTIM;
                end
                else if (steps_reg == tccr_pkg::USED_BITS'(tccr_pkg::SLOT_COUNT))
                begin
                    res_next   = '0;
                    res_next.status = tccr_pkg::ST_FAILED;
                    state_next = S_RESULT;
                end
                else
                begin
                    slot_addr  = scan_after;
                    scan_next  = scan_after;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_VICTIM:
            begin
                if (map_hit && map_slot == slot_reg)
                begin
                    map_addr  = evict_reg;
                    map_we    = 1'b1;
                    map_wdata = '0;
                end
                state_next = S_INSTALL;
            end
            S_INSTALL:
            begin
                map_addr   = entry_cur;
                map_we     = 1'b1;
                map_wdata  = {1'b1, slot_reg};
                slot_addr  = slot_reg;
                slot_we    = 1'b1;
                slot_wdata = {entry_cur, frame_reg};
                used_next  = used_reg + 1'b1;
                loads_next = loads_reg + 1'b1;
                res_next   = make_result(tccr_pkg::ST_LOADED, slot_reg, tile_reg,
                                         evict_reg, loads_reg);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            sweep_reg <= '0;
            tile_reg  <= '0;
            slot_reg  <= '0;
            ptr_reg   <= '0;
            scan_reg  <= '0;
            steps_reg <= '0;
            evict_reg <= '0;
            frame_reg <= '0;
            used_reg  <= '0;
            loads_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            tile_reg  <= tile_next;
            slot_reg  <= slot_next;
            ptr_reg   <= ptr_next;
            scan_reg  <= scan_next;
            steps_reg <= steps_next;
            evict_reg <= evict_next;
            frame_reg <= frame_next;
            used_reg  <= used_next;
            loads_reg <= loads_next;
            res_reg   <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_loads_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loads_reg <= tccr_pkg::LOAD_BITS'(tccr_pkg::MAX_LOADS))
        else $error("load count above limit");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= tccr_pkg::USED_BITS'(tccr_pkg::SLOT_COUNT))
        else $error("used slot count above slot count");

    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op == tccr_pkg::OP_FRAME |=>
        res_valid && res.status == tccr_pkg::ST_FRAME && loads_reg == '0 && used_reg == '0)
        else $error("frame start did not clear counters");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_valid)
        else $error("input taken while a result is pending");

    a_loaded_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INSTALL |=> loads_reg == $past(loads_reg) + 1'b1 &&
        res.status == tccr_pkg::ST_LOADED)
        else $error("load not counted");
`endif

endmodule

// File: tb/tile_cache_frame_protected_replace_top_test.sv
`timescale 1ns / 1ps
// tile_cache_frame_protected_replace_top_test: stream testbench for the tile cache slot mapper
// drives requests and frame starts, predicts each lookup and checks every result word
// depends on tccr_pkg and tile_cache_frame_protected_replace_top

module tile_cache_frame_protected_replace_top_test;

    localparam int          RANDOM_WORDS = 1900;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          DRAIN_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT  = 5000000;
    localparam int          TILE_MAX     = (1 << tccr_pkg::TILE_IN_W) - 1;

    class tile_slot_scoreboard;
        logic                            entry_live  [tccr_pkg::ENTRY_COUNT];
        logic [tccr_pkg::MAP_W-1:0]      entry_slot  [tccr_pkg::ENTRY_COUNT];
        logic [tccr_pkg::ENTRY_BITS-1:0] slot_entry  [tccr_pkg::SLOT_COUNT];
        logic [tccr_pkg::STAMP_BITS-1:0] slot_frame  [tccr_pkg::SLOT_COUNT];
        int                              sweep_ptr;
        logic [tccr_pkg::STAMP_BITS-1:0] frame_no;
        int                              used_slots;
        int                              frame_loads;
        tccr_pkg::result_t               lookups_due [$];
        int                              failures;
        int                              words_seen;

        function new();
            for (int e = 0; e < tccr_pkg::ENTRY_COUNT; e++)
            begin
                entry_live[e] = 1'b0;
                entry_slot[e] = '0;
            end
            for (int s = 0; s < tccr_pkg::SLOT_COUNT; s++)
            begin
                slot_entry[s] = tccr_pkg::ENTRY_BITS'(s % tccr_pkg::ENTRY_COUNT);
                slot_frame[s] = '0;
                if (s < tccr_pkg::ENTRY_COUNT)
                begin
                    entry_live[s] = 1'b1;
                    entry_slot[s] = tccr_pkg::MAP_W'(s);
                end
            end
            sweep_ptr   = 0;
            frame_no    = '0;
            used_slots  = 0;
            frame_loads = 0;
            failures    = 0;
            words_seen  = 0;
        endfunction

        function void mismatch(string msg);
            failures++;
            if (failures <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void lookup_tile(logic op, int tile);
            tccr_pkg::result_t               r;
            logic [tccr_pkg::ENTRY_BITS-1:0] entry;
            logic [tccr_pkg::ENTRY_BITS-1:0] victim;
            int                              t;
            int                              offset;
            int                              slot;
            int                              steps;
            logic                            found;
            r = '0;
            if (op == tccr_pkg::OP_FRAME)
            begin
                frame_no    = frame_no + 1'b1;
                used_slots  = 0;
                frame_loads = 0;
                r.status    = tccr_pkg::ST_FRAME;
                lookups_due.push_back(r);
                return;
            end
            t      = tile & ((1 << tccr_pkg::TILE_BITS) - 1);
            entry  = tccr_pkg::ENTRY_BITS'(t >> tccr_pkg::ENTRY_SHIFT);
            offset = t & tccr_pkg::OFFSET_MASK;
            if (entry_live[entry] && entry_slot[entry] < tccr_pkg::SLOT_COUNT)
            begin
                slot     = entry_slot[entry];
                r.status = tccr_pkg::ST_HIT;
            end
            else
            begin
                if (used_slots >= tccr_pkg::SLOT_COUNT || frame_loads >= tccr_pkg::MAX_LOADS)
                begin
                    r.status = tccr_pkg::ST_FAILED;
                    lookups_due.push_back(r);
                    return;
                end
                // round robin past slots already used this frame
                found = 1'b0;
                steps = 0;
                while (steps < tccr_pkg::SLOT_COUNT && !found)
                begin
                    sweep_ptr = (sweep_ptr + 1 >= tccr_pkg::SLOT_COUNT) ? 0 : sweep_ptr + 1;
                    steps++;
                    if (slot_frame[sweep_ptr] != frame_no)
                        found = 1'b1;
                end
                if (!found)
                begin
                    r.status = tccr_pkg::ST_FAILED;
                    lookups_due.push_back(r);
                    return;
                end
                slot   = sweep_ptr;
                victim = slot_entry[slot];
                if (entry_live[victim] && entry_slot[victim] == slot)
                    entry_live[victim] = 1'b0;
                entry_live[entry]  = 1'b1;
                entry_slot[entry]  = tccr_pkg::MAP_W'(slot);
                slot_entry[slot]   = entry;
                r.evicted_entry    = tccr_pkg::EVICT_W'(victim);
                r.load_position    = tccr_pkg::POS_W'(frame_loads);
                frame_loads++;
                r.status = tccr_pkg::ST_LOADED;
            end
            if (slot_frame[slot] != frame_no)
            begin
                used_slots++;
                slot_frame[slot] = frame_no;
            end
            r.slot         = tccr_pkg::SLOT_OUT_W'(slot);
            r.texture_tile = tccr_pkg::TEX_W'((slot << tccr_pkg::ENTRY_SHIFT) + offset);
            lookups_due.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
                mismatch($sformatf("word %0d %s expected %0d got %0d",
                                   words_seen, name, want, got));
        endfunction

        function void check_word(logic [1:0] st, logic [tccr_pkg::OUT_DATA_W-1:0] data);
            tccr_pkg::result_t want;
            tccr_pkg::result_t got;
            got.status = tccr_pkg::status_t'(st);
            {got.load_position, got.evicted_entry, got.texture_tile, got.slot} =
                data[tccr_pkg::OUT_FIELDS_W-1:0];
            if (lookups_due.size() == 0)
            begin
                mismatch($sformatf("unexpected word status %0d data %h", st, data));
                return;
            end
            want = lookups_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("slot", want.slot, got.slot);
            compare_field("texture_tile", want.texture_tile, got.texture_tile);
            compare_field("evicted_entry", want.evicted_entry, got.evicted_entry);
            compare_field("load_position", want.load_position, got.load_position);
            words_seen++;
        endfunction

        function void check_leftovers();
            if (lookups_due.size() != 0)
                mismatch($sformatf("%0d results never arrived", lookups_due.size()));
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [tccr_pkg::IN_DATA_W-1:0]  s_axis_tdata;    // tile_number
    logic                            s_axis_tuser;    // operation
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [tccr_pkg::OUT_DATA_W-1:0] m_axis_tdata;    // slot, texture_tile, evicted_entry, load_position
    logic [1:0]                      m_axis_tuser;    // status

    tile_slot_scoreboard sb = new();

    logic        quiet;
    logic        hold_off_req;
    int          rand_words;
    int unsigned cycles;

    tile_cache_frame_protected_replace_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[tile_cache_frame_protected_replace_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tuser, m_axis_tdata);

    initial
    begin : receiver
        int   k;
        logic held;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
            end
            else
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic send_word(input logic op, input int tile);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= tccr_pkg::IN_DATA_W'(tile & TILE_MAX);
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sb.lookup_tile(op, tile & TILE_MAX);
    endtask

    task automatic frame_item(input logic op, input int tile);
        send_word(op, tile);
        rand_words++;
        if (rand_words == 400)
            hold_off_req = 1'b1;
        quiet = (rand_words >= 1100 && rand_words < 1400);
    endtask

    function automatic int tile_of_slot(int s);
        return (int'(sb.slot_entry[s]) << tccr_pkg::ENTRY_SHIFT)
               | $urandom_range(0, tccr_pkg::OFFSET_MASK);
    endfunction

    function automatic int fresh_tile();
        return ($urandom_range(0, tccr_pkg::ENTRY_COUNT - 1) << tccr_pkg::ENTRY_SHIFT)
               | $urandom_range(0, tccr_pkg::OFFSET_MASK);
    endfunction

    initial
    begin : stimulus
        int   slot_order [tccr_pkg::SLOT_COUNT];
        int   pick;
        int   n;
        int   j;
        int   tmp;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tccr_pkg::OP_REQUEST;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        rand_words    = 0;
        cycles        = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every slot carries the current stamp right after reset, so misses fail
        send_word(tccr_pkg::OP_REQUEST, (300 << tccr_pkg::ENTRY_SHIFT) | 5);
        send_word(tccr_pkg::OP_REQUEST, 0);
        send_word(tccr_pkg::OP_REQUEST, TILE_MAX);
        send_word(tccr_pkg::OP_REQUEST,
                  ((tccr_pkg::SLOT_COUNT - 1) << tccr_pkg::ENTRY_SHIFT) | tccr_pkg::OFFSET_MASK);
        send_word(tccr_pkg::OP_FRAME, TILE_MAX);
        send_word(tccr_pkg::OP_REQUEST, TILE_MAX);
        send_word(tccr_pkg::OP_REQUEST, (1 << tccr_pkg::ENTRY_SHIFT));
        send_word(tccr_pkg::OP_REQUEST, TILE_MAX - tccr_pkg::OFFSET_MASK);
        send_word(tccr_pkg::OP_REQUEST, (2 << tccr_pkg::ENTRY_SHIFT) | 3);
        send_word(tccr_pkg::OP_REQUEST, (1 << tccr_pkg::ENTRY_SHIFT) | 1);
        send_word(tccr_pkg::OP_FRAME, 0);
        send_word(tccr_pkg::OP_REQUEST, (1 << tccr_pkg::ENTRY_SHIFT) | 1);
        send_word(tccr_pkg::OP_REQUEST,
                  ((tccr_pkg::ENTRY_COUNT / 2) << tccr_pkg::ENTRY_SHIFT) | 6);
        send_word(tccr_pkg::OP_REQUEST, 3 << tccr_pkg::ENTRY_SHIFT);
        send_word(tccr_pkg::OP_REQUEST, (3 << tccr_pkg::ENTRY_SHIFT) | tccr_pkg::OFFSET_MASK);
        send_word(tccr_pkg::OP_FRAME, 12345);

        for (int s = 0; s < tccr_pkg::SLOT_COUNT; s++)
            slot_order[s] = s;

        while (rand_words < RANDOM_WORDS)
        begin
            frame_item(tccr_pkg::OP_FRAME, $urandom_range(0, TILE_MAX));
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // hit 100 up to all distinct slots, then miss into a frame with those slots used
                for (int s = tccr_pkg::SLOT_COUNT - 1; s > 0; s--)
                begin
                    j             = $urandom_range(0, s);
                    tmp           = slot_order[s];
                    slot_order[s] = slot_order[j];
                    slot_order[j] = tmp;
                end
                n = $urandom_range(100, tccr_pkg::SLOT_COUNT);
                for (int k = 0; k < n; k++)
                    frame_item(tccr_pkg::OP_REQUEST, tile_of_slot(slot_order[k]));
                repeat ($urandom_range(2, 10))
                    frame_item(tccr_pkg::OP_REQUEST, fresh_tile());
            end
            else if (pick < 40)
            begin
                // run into the per-frame load limit
                repeat ($urandom_range(70, 110))
                    frame_item(tccr_pkg::OP_REQUEST, ($urandom_range(0, 99) < 15)
                               ? tile_of_slot($urandom_range(0, tccr_pkg::SLOT_COUNT - 1))
                               : fresh_tile());
            end
            else
            begin
                repeat ($urandom_range(10, 150))
                begin
                    n = $urandom_range(0, 99);
                    if (n < 45)
                        frame_item(tccr_pkg::OP_REQUEST,
                                   tile_of_slot($urandom_range(0, tccr_pkg::SLOT_COUNT - 1)));
                    else if (n < 85)
                        frame_item(tccr_pkg::OP_REQUEST, fresh_tile());
                    else
                        frame_item(tccr_pkg::OP_REQUEST, $urandom_range(0, TILE_MAX));
                end
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.lookups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_leftovers();
        if (sb.failures == 0)
            $display("[tile_cache_frame_protected_replace_top] OK");
        else
            $display("[tile_cache_frame_protected_replace_top] ERROR");
        $finish;
    end

endmodule
